// File: sv/tlc_pkg.sv
`default_nettype none
package tlc_pkg;

  localparam int unsigned TIME_BITS = 20;
  localparam int unsigned OUT_W     = 20;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned CMP_W     = (TIME_BITS > OUT_W) ? TIME_BITS : OUT_W;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  localparam logic [MS_W-1:0] TRANSITION_RST = 16'd1000;
  localparam logic [MS_W-1:0] NORMAL_RST     = 16'd15000;
  localparam logic [MS_W-1:0] LONG_RST       = 16'd30000;
  localparam logic [MS_W-1:0] SHORT_RST      = 16'd5000;

  typedef logic [TIME_BITS-1:0] timer_t;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_FORCE   = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_PRIO_MODE  = 3'd0,
    REG_PRIO_LANE  = 3'd1,
    REG_TRANSITION = 3'd2,
    REG_NORMAL     = 3'd3,
    REG_LONG       = 3'd4,
    REG_SHORT      = 3'd5
  } reg_e;

  typedef struct packed {
    logic            priority_mode;
    logic            priority_lane;
    logic [MS_W-1:0] transition_ms;
    logic [MS_W-1:0] normal_ms;
    logic [MS_W-1:0] long_ms;
    logic [MS_W-1:0] short_ms;
  } cfg_t;

  typedef struct packed {
    logic   cur_light;
    logic   target_light;
    logic   changing;
    logic   hold_flag;
    timer_t dwell_timer;
    timer_t change_timer;
  } state_t;

  function automatic timer_t sat_add(timer_t t, logic [MS_W-1:0] d);
    logic [TIME_BITS:0] s;
    s = {1'b0, t} + (TIME_BITS+1)'(d);
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(timer_t t);
    logic [CMP_W-1:0] w;
    w = CMP_W'(t);
    return (w > CMP_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(w);
  endfunction

endpackage
`default_nettype wire

// File: sv/tlc_if.sv
`default_nettype none
interface tlc_in_if import tlc_pkg::*;;
  logic              valid;
  logic              ready;
  cmd_e              cmd;
  logic [MS_W-1:0]   delta_ms;
  logic              light;

  modport source (output valid, cmd, delta_ms, light, input ready);
  modport sink   (input valid, cmd, delta_ms, light, output ready);
endinterface

interface tlc_out_if import tlc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              light_now;
  logic              light_next;
  logic              in_transition;
  logic              held;
  logic [OUT_W-1:0]  transition_elapsed;
  logic [OUT_W-1:0]  dwell_elapsed;

  modport source (output valid, light_now, light_next, in_transition, held,
                  transition_elapsed, dwell_elapsed, input ready);
  modport sink   (input valid, light_now, light_next, in_transition, held,
                  transition_elapsed, dwell_elapsed, output ready);
endinterface
`default_nettype wire

// File: sv/tlc_cfg_regs.sv
`default_nettype none
module tlc_cfg_regs import tlc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e idx;
  logic wr_en;

  assign pready = 1'b1;
  assign idx    = reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_PRIO_MODE:  cfg_d.priority_mode = pwdata[0];
        REG_PRIO_LANE:  cfg_d.priority_lane = pwdata[0];
        REG_TRANSITION: cfg_d.transition_ms = pwdata[MS_W-1:0];
        REG_NORMAL:     cfg_d.normal_ms     = pwdata[MS_W-1:0];
        REG_LONG:       cfg_d.long_ms       = pwdata[MS_W-1:0];
        REG_SHORT:      cfg_d.short_ms      = pwdata[MS_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PRIO_MODE:  prdata = DATA_W'(cfg_q.priority_mode);
      REG_PRIO_LANE:  prdata = DATA_W'(cfg_q.priority_lane);
      REG_TRANSITION: prdata = DATA_W'(cfg_q.transition_ms);
      REG_NORMAL:     prdata = DATA_W'(cfg_q.normal_ms);
      REG_LONG:       prdata = DATA_W'(cfg_q.long_ms);
      REG_SHORT:      prdata = DATA_W'(cfg_q.short_ms);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.priority_mode <= 1'b0;
      cfg_q.priority_lane <= 1'b0;
      cfg_q.transition_ms <= TRANSITION_RST;
      cfg_q.normal_ms     <= NORMAL_RST;
      cfg_q.long_ms       <= LONG_RST;
      cfg_q.short_ms      <= SHORT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: sv/tlc_state.sv
`default_nettype none
module tlc_state import tlc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire cmd_e            cmd_i,
  input  wire logic [MS_W-1:0] delta_i,
  input  wire logic            light_i,
  input  wire cfg_t            cfg_i,
  output state_t               nxt_o
);

  state_t st_q, st_d;
  timer_t dw_sum, ch_sum;
  logic [MS_W-1:0] dwell_ms;
  logic req_go;

  always_comb begin
    if (!cfg_i.priority_mode) begin
      dwell_ms = cfg_i.normal_ms;
    end else if (cfg_i.priority_lane) begin
      dwell_ms = st_q.cur_light ? cfg_i.long_ms : cfg_i.short_ms;
    end else begin
      dwell_ms = st_q.cur_light ? cfg_i.short_ms : cfg_i.long_ms;
    end
  end

  assign dw_sum = sat_add(st_q.dwell_timer, delta_i);
  assign ch_sum = sat_add(st_q.change_timer, delta_i);
  assign req_go = (light_i != st_q.cur_light) && !st_q.changing;

  always_comb begin
    st_d = st_q;
    case (cmd_i)
      CMD_TICK: begin
        if (!st_q.hold_flag) begin
          st_d.dwell_timer = dw_sum;
          if (st_q.changing) begin
            st_d.change_timer = ch_sum;
            if (ch_sum >= TIME_BITS'(cfg_i.transition_ms)) begin
              st_d.cur_light    = st_q.target_light;
              st_d.changing     = 1'b0;
              st_d.change_timer = '0;
              st_d.dwell_timer  = '0;
            end
          end else if (dw_sum >= TIME_BITS'(dwell_ms)) begin
            st_d.target_light = ~st_q.cur_light;
            st_d.changing     = 1'b1;
            st_d.change_timer = '0;
            st_d.dwell_timer  = '0;
          end
        end
      end
      CMD_FORCE: begin
        st_d.hold_flag    = 1'b1;
        st_d.cur_light    = light_i;
        st_d.target_light = light_i;
        st_d.changing     = 1'b0;
        st_d.change_timer = '0;
        st_d.dwell_timer  = '0;
      end
      CMD_REQUEST, CMD_RELEASE: begin
        if (cmd_i == CMD_RELEASE) begin
          st_d.hold_flag = 1'b0;
        end
        if (req_go) begin
          st_d.target_light = light_i;
          st_d.changing     = 1'b1;
          st_d.change_timer = '0;
          st_d.dwell_timer  = '0;
        end
      end
      default: st_d = st_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept_i) begin
      st_q <= st_d;
    end
  end

  assign nxt_o = st_d;

endmodule
`default_nettype wire

// File: sv/tlc_out_reg.sv
`default_nettype none
module tlc_out_reg import tlc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   load_i,
  input  wire state_t st_i,
  output logic        busy_o,
  tlc_out_if.source   out_if
);

  logic             valid_q, valid_d;
  logic             light_now_q, light_next_q, trans_q, held_q;
  logic [OUT_W-1:0] trans_el_q, dwell_el_q;

  // result slot frees when the receiver takes it or is about to
  assign busy_o  = valid_q && !out_if.ready;
  assign valid_d = load_i || busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      light_now_q  <= st_i.cur_light;
      light_next_q <= st_i.target_light;
      trans_q      <= st_i.changing;
      held_q       <= st_i.hold_flag;
      trans_el_q   <= sat_out(st_i.change_timer);
      dwell_el_q   <= sat_out(st_i.dwell_timer);
    end
  end

  assign out_if.valid              = valid_q;
  assign out_if.light_now          = light_now_q;
  assign out_if.light_next         = light_next_q;
  assign out_if.in_transition      = trans_q;
  assign out_if.held               = held_q;
  assign out_if.transition_elapsed = trans_el_q;
  assign out_if.dwell_elapsed      = dwell_el_q;

endmodule
`default_nettype wire

// File: sv/traffic_light_controller.sv
// Red/green signal controller with millisecond dwell and transition timers.
//
// in_if carries one request per handshake: a tick with elapsed milliseconds,
// a light request, a forced hold, or a hold release with a request. Every
// request gives exactly one result on out_if: the lights, the transition and
// hold flags and both elapsed times, as they stand after the request.
// The APB port sets the mode, lane and the four times; write it only while
// no result is outstanding.
//
// Each result is registered: the output register loads it at the edge that
// accepts the request. Throughput is one request per cycle while the receiver
// takes each result; the state registers update on each accepted request.
// in_if.ready stays high while the result register is empty or being taken,
// so a stalled receiver holds back at most the one result that waits.
// Reset returns the state to red with no transition, no hold and cleared timers,
// and the registers to their default values; no result is pending afterwards.
`default_nettype none
module traffic_light_controller import tlc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  tlc_in_if.sink                 in_if,
  tlc_out_if.source              out_if,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t   cfg;
  state_t nxt;
  logic   busy;
  logic   accept;

  assign in_if.ready = !busy;
  assign accept      = in_if.valid && !busy;

  tlc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tlc_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (in_if.cmd),
    .delta_i  (in_if.delta_ms),
    .light_i  (in_if.light),
    .cfg_i    (cfg),
    .nxt_o    (nxt)
  );

  tlc_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .st_i   (nxt),
    .busy_o (busy),
    .out_if (out_if)
  );

endmodule
`default_nettype wire

// File: sv/tlc_checker.sv
`default_nettype none
module tlc_checker import tlc_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             light_now,
  input wire logic             light_next,
  input wire logic             in_transition,
  input wire logic [OUT_W-1:0] transition_elapsed
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(light_now) &&
      $stable(light_next) && $stable(transition_elapsed))
    else $error("result changed while stalled");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("request refused with empty result register");

  a_steady_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !in_transition |-> light_now == light_next)
    else $error("target differs from light with no transition");

  a_change_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && in_transition |-> light_now != light_next)
    else $error("transition towards the light already shown");

  a_idle_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !in_transition |-> transition_elapsed == '0)
    else $error("transition time counted outside a transition");

endmodule

bind traffic_light_controller tlc_checker u_tlc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready           (in_if.ready),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .light_now          (out_if.light_now),
  .light_next         (out_if.light_next),
  .in_transition      (out_if.in_transition),
  .transition_elapsed (out_if.transition_elapsed)
);
`default_nettype wire
